// File: rtl/core/efo_pkg.sv
// Shared types, codes and constants for the extent block to file offset unit.
package efo_pkg;

  // Default table depth and fixed field widths.
  localparam int MAX_EXTENTS_DEF = 32;
  localparam int UNIT_SHIFT      = 10;
  localparam int BLK_W           = 48;
  localparam int OFS_W           = 32;
  localparam int IN_DATA_W       = 192;

  // Operation codes carried in the input tuser.
  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // Result status codes carried in the output tuser.
  localparam logic [1:0] ST_TRANSLATED = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_LOADED     = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENTRIES_IN_USE      = 2'd0;
  localparam logic [1:0] REG_EXTENTS_PER_FILE    = 2'd1;
  localparam logic [1:0] REG_FILES_PER_PARTITION = 2'd2;
  localparam logic [1:0] REG_DIV_SHIFT           = 2'd3;

  // Configuration reset values.
  localparam logic [5:0] RST_ENTRIES_IN_USE      = 6'd0;
  localparam logic [7:0] RST_EXTENTS_PER_FILE    = 8'd2;
  localparam logic [7:0] RST_FILES_PER_PARTITION = 8'd4;
  localparam logic [4:0] RST_DIV_SHIFT           = 5'd0;

  // One extent table row.
  typedef struct packed {
    logic [47:0] first_block;
    logic [15:0] size_units;
    logic [15:0] partition;
    logic [31:0] file_base;
    logic [3:0]  width_bytes;
    logic [15:0] segment;
  } row_t;

  // Request to the shared multiply-add unit: acc <= addend + a * b.
  typedef struct packed {
    logic        load;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] addend;
  } mac_req_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_MAC0,
    S_MAC1,
    S_MAC2,
    S_MAC3,
    S_MAC4,
    S_FINISH
  } state_t;

  // Shift for a column width: index of its highest set bit, zero for zero.
  function automatic logic [1:0] width_shift(input logic [3:0] w);
    logic [1:0] s;
    s = 2'd0;
    if (w[3]) begin
      s = 2'd3;
    end else if (w[2]) begin
      s = 2'd2;
    end else if (w[1]) begin
      s = 2'd1;
    end
    return s;
  endfunction

endpackage

// File: rtl/core/efo_table.sv
// Extent table memory with one write port and one registered read port.
module efo_table #(
  parameter int MAX_EXTENTS = efo_pkg::MAX_EXTENTS_DEF,
  parameter int IDX_W       = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  efo_pkg::row_t     wdata,
  input  logic              re,
  input  logic [IDX_W-1:0]  raddr,
  output efo_pkg::row_t     rdata
);
  import efo_pkg::*;

  row_t mem [MAX_EXTENTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/efo_mac.sv
// Shared 32-bit multiply-add unit used for all index arithmetic.
module efo_mac (
  input  logic              clk,
  input  efo_pkg::mac_req_t req,
  output logic [31:0]       acc
);
  import efo_pkg::*;

  logic [31:0] prod;

  // Product modulo 2^32.
  assign prod = req.a * req.b;

  // Accumulator register.
  always_ff @(posedge clk) begin
    if (req.load) begin
      acc <= req.addend + prod;
    end
  end

endmodule

// File: rtl/core/efo_ctrl.sv
// Sequencer: configuration registers, table scan, index arithmetic and result register.
module efo_ctrl #(
  parameter int MAX_EXTENTS = efo_pkg::MAX_EXTENTS_DEF,
  parameter int IDX_W       = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1,
  parameter int LIM_W       = $clog2(MAX_EXTENTS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration writes.
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  // Input item.
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [4:0]        in_entry_index,
  input  logic [47:0]       in_lookup_block,
  // Table access.
  output logic              tbl_we,
  output logic [IDX_W-1:0]  tbl_waddr,
  output logic              tbl_re,
  output logic [IDX_W-1:0]  tbl_raddr,
  input  efo_pkg::row_t     tbl_rdata,
  // Shared arithmetic unit.
  output efo_pkg::mac_req_t mac_req,
  input  logic [31:0]       mac_acc,
  // Result item.
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [31:0]       out_offset
);
  import efo_pkg::*;

  state_t state, state_next;

  logic [5:0]       entries_in_use;
  logic [7:0]       extents_per_file;
  logic [7:0]       files_per_partition;
  logic [4:0]       div_shift;

  logic [47:0]      blk;
  logic [LIM_W-1:0] scan_lim;
  logic [LIM_W-1:0] ptr;
  logic             pend;
  logic [31:0]      off;
  logic [1:0]       res_status;

  logic             accept;
  logic             issue;
  logic             hit;
  logic             out_load;
  logic [47:0]      diff;
  logic [47:0]      span;
  logic [31:0]      stripe;
  logic [LIM_W-1:0] lim_in;
  logic [1:0]       res_status_next;

  assign accept = in_valid && in_ready;

  // Scan count clamped to the table depth.
  always_comb begin
    if ({26'd0, entries_in_use} > 32'(MAX_EXTENTS)) begin
      lim_in = LIM_W'(MAX_EXTENTS);
    end else begin
      lim_in = LIM_W'(entries_in_use);
    end
  end

  // Range check on the row read in the previous cycle.
  assign diff = blk - tbl_rdata.first_block;
  assign span = {22'd0, tbl_rdata.size_units, 10'd0};
  assign hit  = pend && (blk >= tbl_rdata.first_block) && (diff < span);

  // Stripe number of the hit extent within its file.
  assign stripe = tbl_rdata.file_base >>
                  ({3'd0, width_shift(tbl_rdata.width_bytes)} + 5'(UNIT_SHIFT));

  // Table write on a load transfer that names a slot inside the table.
  assign tbl_we    = accept && (in_op == OP_LOAD) &&
                     ({27'd0, in_entry_index} < 32'(MAX_EXTENTS));
  assign tbl_waddr = IDX_W'(in_entry_index);

  // Next state, table reads and arithmetic steps.
  always_comb begin
    state_next      = state;
    issue           = 1'b0;
    out_load        = 1'b0;
    res_status_next = res_status;
    mac_req         = '0;
    in_ready        = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            res_status_next = ST_LOADED;
            state_next      = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_status_next = ST_TRANSLATED;
          state_next      = S_MAC0;
        end else if (ptr < scan_lim) begin
          issue = 1'b1;
        end else if (!pend) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_FINISH;
        end
      end
      S_MAC0: begin
        mac_req = '{load: 1'b1, a: {24'd0, extents_per_file},
                    b: {24'd0, files_per_partition}, addend: 32'd0};
        state_next = S_MAC1;
      end
      S_MAC1: begin
        mac_req = '{load: 1'b1, a: {16'd0, tbl_rdata.partition},
                    b: mac_acc, addend: 32'd0};
        state_next = S_MAC2;
      end
      S_MAC2: begin
        mac_req = '{load: 1'b1, a: stripe,
                    b: {24'd0, files_per_partition}, addend: mac_acc};
        state_next = S_MAC3;
      end
      S_MAC3: begin
        mac_req = '{load: 1'b1, a: {16'd0, tbl_rdata.segment},
                    b: 32'd1, addend: mac_acc};
        state_next = S_MAC4;
      end
      S_MAC4: begin
        // The left shift by div_shift is a multiply by a power of two.
        mac_req = '{load: 1'b1, a: mac_acc,
                    b: 32'd1 << div_shift, addend: off};
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign tbl_re    = issue;
  assign tbl_raddr = ptr[IDX_W-1:0];

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use      <= RST_ENTRIES_IN_USE;
      extents_per_file    <= RST_EXTENTS_PER_FILE;
      files_per_partition <= RST_FILES_PER_PARTITION;
      div_shift           <= RST_DIV_SHIFT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENTRIES_IN_USE:      entries_in_use      <= cfg_data[5:0];
        REG_EXTENTS_PER_FILE:    extents_per_file    <= cfg_data;
        REG_FILES_PER_PARTITION: files_per_partition <= cfg_data;
        REG_DIV_SHIFT:           div_shift           <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Scan pointer and read-pending flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      pend <= 1'b0;
    end else if (accept) begin
      ptr  <= '0;
      pend <= 1'b0;
    end else if (state == S_SCAN) begin
      pend <= issue;
      if (issue) begin
        ptr <= ptr + LIM_W'(1);
      end
    end
  end

  // Item payload held for the scan and the offset of a hit.
  always_ff @(posedge clk) begin
    if (accept) begin
      blk      <= in_lookup_block;
      scan_lim <= lim_in;
    end
    if (state == S_SCAN && hit) begin
      off <= diff[31:0];
    end
    res_status <= res_status_next;
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_offset <= (res_status == ST_TRANSLATED) ? mac_acc : 32'd0;
    end
  end

endmodule

// File: rtl/core/extent_block_to_file_offset_unit.sv
// Top level of the extent block to file offset unit.
//
// Input items arrive as stream transfers on s_*: s_tuser selects a load
// (write one extent table slot) or a translation of a logical block.
// Every item gives exactly one result transfer on m_*, whose tuser is the
// status and whose tdata is the file block offset (zero unless translated).
// Four configuration registers are written over cfg_*; the user must write
// them only while the unit idles; the block does not enforce it. A load
// goes from its transfer through the finish state to the result register.
// A translation reads one table row per cycle from the extent memory, from
// slot 0 until a hit, or through entries_in_use slots (clamped to the
// depth) for a miss; then the multiply-add unit runs the index arithmetic
// in S_MAC0 to S_MAC4. The unit takes one item at a time; s_tready is high
// only while it waits for an item. If the receiver stalls, the result
// stays in the output register and the unit holds until it is taken.
// Reset clears the sequencer and sets the registers to their defaults;
// table contents are undefined until loaded.
module extent_block_to_file_offset_unit #(
  parameter int MAX_EXTENTS = efo_pkg::MAX_EXTENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata from bit 0: entry_index[5], range_start[48], range_units[16],
  // partition_number[16], file_block_base[32], column_bytes[4],
  // segment_number[16], lookup_block[48], zero pad[7].
  input  logic [efo_pkg::IN_DATA_W-1:0] s_tdata,
  // tuser: operation[1].
  input  logic        s_tuser,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: file_offset[32].
  output logic [31:0] m_tdata,
  // tuser: status[2].
  output logic [1:0]  m_tuser
);
  import efo_pkg::*;

  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int LIM_W = $clog2(MAX_EXTENTS + 1);

  row_t             wrow;
  row_t             rrow;
  logic             tbl_we;
  logic             tbl_re;
  logic [IDX_W-1:0] tbl_waddr;
  logic [IDX_W-1:0] tbl_raddr;
  mac_req_t         mac_req;
  logic [31:0]      mac_acc;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Unpack the table row carried by a load.
  assign wrow.first_block = s_tdata[52:5];
  assign wrow.size_units  = s_tdata[68:53];
  assign wrow.partition   = s_tdata[84:69];
  assign wrow.file_base   = s_tdata[116:85];
  assign wrow.width_bytes = s_tdata[120:117];
  assign wrow.segment     = s_tdata[136:121];

  efo_table #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (wrow),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (rrow)
  );

  efo_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .acc (mac_acc)
  );

  efo_ctrl #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .IDX_W       (IDX_W),
    .LIM_W       (LIM_W)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .in_op           (s_tuser),
    .in_entry_index  (s_tdata[4:0]),
    .in_lookup_block (s_tdata[184:137]),
    .tbl_we          (tbl_we),
    .tbl_waddr       (tbl_waddr),
    .tbl_re          (tbl_re),
    .tbl_raddr       (tbl_raddr),
    .tbl_rdata       (rrow),
    .mac_req         (mac_req),
    .mac_acc         (mac_acc),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_status      (m_tuser),
    .out_offset      (m_tdata)
  );

endmodule
